/* hw/rtl/distributed_mutex_node_defines.svh */
// assertion macros for the distributed mutex node
`ifndef DISTRIBUTED_MUTEX_NODE_DEFINES_SVH
`define DISTRIBUTED_MUTEX_NODE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define DMN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmn assertion failed");

// consequent holds in the cycle after the antecedent
`define DMN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmn assertion failed");

`endif

/* hw/rtl/dmn_pkg.sv */
// shared types, constants and helper functions of the distributed mutex node
package dmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int KIND_W    = 3;
  localparam int SEQ_W     = 32;
  localparam int ID_W      = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    IK_LOCAL_REQ  = 3'd0,
    IK_PEER_REQ   = 3'd1,
    IK_PEER_REPLY = 3'd2,
    IK_RELEASE    = 3'd3,
    IK_LEAVE      = 3'd4,
    IK_GOODBYE    = 3'd5,
    IK_DONE       = 3'd6
  } in_kind_t;

  typedef enum logic [KIND_W-1:0] {
    M_NONE    = 3'd0,
    M_GRANT   = 3'd1,
    M_REQUEST = 3'd2,
    M_REPLY   = 3'd3,
    M_LEAVE   = 3'd4,
    M_GOODBYE = 3'd5
  } msg_kind_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] popcnt(logic [MAX_NODES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_NODES; i++) n = n + CNT_W'(v[i]);
    return n;
  endfunction

  function automatic logic [NODE_W-1:0] lowest_idx(logic [MAX_NODES-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) r = NODE_W'(i);
    end
    return r;
  endfunction

  // node count used clamped to 1..MAX_NODES
  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = c;
    if (c == '0) r = COUNT_W'(1);
    else if (c > COUNT_W'(MAX_NODES)) r = COUNT_W'(MAX_NODES);
    return r;
  endfunction

endpackage

/* hw/rtl/dmn_in_if.sv */
// input channel of the distributed mutex node
interface dmn_in_if import dmn_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     source_node;
  logic [SEQ_W-1:0]    sequence_req;

  modport source (output valid, kind, source_node, sequence_req, input ready);
  modport sink (input valid, kind, source_node, sequence_req, output ready);
endinterface

/* hw/rtl/dmn_out_if.sv */
// result channel of the distributed mutex node
interface dmn_out_if import dmn_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   message_kind;
  logic [ID_W-1:0]     destination_node;
  logic [SEQ_W-1:0]    message_sequence;
  logic                last_of_run;
  logic                finished;

  modport source (output valid, message_kind, destination_node, message_sequence,
                  last_of_run, finished, input ready);
  modport sink (input valid, message_kind, destination_node, message_sequence,
                last_of_run, finished, output ready);
endinterface

/* hw/rtl/dmn_ctrl.sv */
// controller: takes one item, then pops its messages into the output register
module dmn_ctrl import dmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_ready && in_valid;
  // output register free or draining this cycle
  assign cmd.emit   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit && stat.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/dmn_dp.sv */
// datapath: node state, per-item message plan and output register
module dmn_dp import dmn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_W-1:0]      in_source_node,
  input  logic [SEQ_W-1:0]     in_sequence_req,
  output logic [KIND_W-1:0]    out_message_kind,
  output logic [ID_W-1:0]      out_destination_node,
  output logic [SEQ_W-1:0]     out_message_sequence,
  output logic                 out_last_of_run,
  output logic                 out_finished
);

  // configuration
  logic [ID_W-1:0]      node_id_r;
  logic [COUNT_W-1:0]   node_count_r;

  // protocol state
  logic [SEQ_W-1:0]     own_seq_r, own_seq_nxt;
  logic [SEQ_W-1:0]     high_seq_r, high_seq_nxt;
  logic                 requesting_r, requesting_nxt;
  logic [CNT_W-1:0]     ro_r, ro_nxt;
  logic [MAX_NODES-1:0] replied_r, replied_nxt;
  logic [MAX_NODES-1:0] deferred_r, deferred_nxt;
  logic [MAX_NODES-1:0] alive_r, alive_nxt;
  logic [CNT_W-1:0]     alive_cnt_r, alive_cnt_nxt;
  logic [MAX_NODES-1:0] gb_r, gb_nxt;
  logic [CNT_W-1:0]     go_r, go_nxt;
  logic                 leaving_r, leaving_nxt;
  logic                 done_r, done_nxt;

  // message plan of the current item
  logic                 grant_r, grant_nxt;
  logic [MAX_NODES-1:0] set_a_r, set_a_nxt;
  msg_kind_t            a_kind_r, a_kind_nxt;
  logic [MAX_NODES-1:0] set_b_r, set_b_nxt;
  logic                 tail_r, tail_nxt;
  msg_kind_t            tail_kind_r, tail_kind_nxt;
  logic [ID_W-1:0]      tail_dest_r, tail_dest_nxt;

  // output register
  msg_kind_t            out_kind_r;
  logic [ID_W-1:0]      out_dest_r;
  logic [SEQ_W-1:0]     out_seq_r;
  logic                 out_last_r;
  logic                 out_fin_r;

  logic [COUNT_W-1:0]   eff;
  logic [MAX_NODES-1:0] member_mask, self_bit, live, sbit;
  logic [CNT_W-1:0]     live_cnt, ro_dec, go_dec;
  logic                 peer_ok;

  // planned item
  logic                 ev_grant, ev_tail;
  logic [MAX_NODES-1:0] ev_set_a, ev_set_b;
  msg_kind_t            ev_a_kind, ev_tail_kind;
  logic [ID_W-1:0]      ev_tail_dest;

  // message picked this cycle
  msg_kind_t            pick_kind;
  logic [ID_W-1:0]      pick_dest;
  logic [SEQ_W-1:0]     pick_seq;
  logic                 pick_last;
  logic [NODE_W-1:0]    idx_a, idx_b;
  logic [MAX_NODES-1:0] rem_a, rem_b;

  assign eff = clamp_count(node_count_r);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) member_mask[i] = (COUNT_W'(i) < eff);
  end

  assign self_bit = (COUNT_W'(node_id_r) < eff) ? (MAX_NODES'(1) << node_id_r) : '0;
  assign live     = alive_r & member_mask & ~self_bit;
  assign live_cnt = popcnt(live);
  assign sbit     = MAX_NODES'(1) << in_source_node;
  assign peer_ok  = (COUNT_W'(in_source_node) < eff) && (in_source_node != node_id_r);
  assign ro_dec   = (ro_r != '0) ? ro_r - CNT_W'(1) : '0;
  assign go_dec   = (go_r != '0) ? go_r - CNT_W'(1) : '0;

  // state update and message plan for one accepted item
  always_comb begin
    own_seq_nxt    = own_seq_r;
    high_seq_nxt   = high_seq_r;
    requesting_nxt = requesting_r;
    ro_nxt         = ro_r;
    replied_nxt    = replied_r;
    deferred_nxt   = deferred_r;
    alive_nxt      = alive_r;
    alive_cnt_nxt  = alive_cnt_r;
    gb_nxt         = gb_r;
    go_nxt         = go_r;
    leaving_nxt    = leaving_r;
    done_nxt       = done_r;
    ev_grant       = 1'b0;
    ev_set_a       = '0;
    ev_a_kind      = M_REPLY;
    ev_set_b       = '0;
    ev_tail        = 1'b0;
    ev_tail_kind   = M_NONE;
    ev_tail_dest   = '0;
    if (!done_r) begin
      case (in_kind_t'(in_kind))
        IK_LOCAL_REQ: begin
          if (!requesting_r) begin
            requesting_nxt = 1'b1;
            own_seq_nxt    = high_seq_r + SEQ_W'(1);
            replied_nxt    = ~live;
            ro_nxt         = live_cnt;
            ev_grant       = (live_cnt == '0);
            ev_set_a       = live;
            ev_a_kind      = M_REQUEST;
          end
        end
        IK_PEER_REQ: begin
          if (peer_ok) begin
            if (in_sequence_req > high_seq_r) high_seq_nxt = in_sequence_req;
            // defer requests that rank after our own
            if (requesting_r && (in_sequence_req > own_seq_r ||
                (in_sequence_req == own_seq_r && in_source_node > node_id_r))) begin
              deferred_nxt = deferred_r | sbit;
            end else begin
              ev_tail      = 1'b1;
              ev_tail_kind = M_REPLY;
              ev_tail_dest = in_source_node;
            end
          end
        end
        IK_PEER_REPLY: begin
          if (peer_ok && requesting_r && !(|(replied_r & sbit))) begin
            replied_nxt = replied_r | sbit;
            ro_nxt      = ro_dec;
            ev_grant    = (ro_dec == '0);
          end
        end
        IK_RELEASE: begin
          if (requesting_r) begin
            requesting_nxt = 1'b0;
            ev_set_a       = deferred_r & member_mask;
            ev_a_kind      = M_REPLY;
            deferred_nxt   = '0;
          end
        end
        IK_LEAVE: begin
          if (peer_ok) begin
            if (|(alive_r & sbit)) begin
              alive_nxt = alive_r & ~sbit;
              if (alive_cnt_r != '0) alive_cnt_nxt = alive_cnt_r - CNT_W'(1);
            end
            if (requesting_r && !(|(replied_r & sbit))) begin
              replied_nxt = replied_r | sbit;
              ro_nxt      = ro_dec;
              ev_grant    = (ro_dec == '0);
            end
            if (leaving_r && !(|(gb_r & sbit))) begin
              gb_nxt = gb_r | sbit;
              go_nxt = go_dec;
              if (go_dec == '0) done_nxt = 1'b1;
            end
            ev_tail      = 1'b1;
            ev_tail_kind = M_GOODBYE;
            ev_tail_dest = in_source_node;
          end
        end
        IK_GOODBYE: begin
          if (peer_ok && leaving_r && !(|(gb_r & sbit))) begin
            gb_nxt = gb_r | sbit;
            go_nxt = go_dec;
            if (go_dec == '0) done_nxt = 1'b1;
          end
        end
        IK_DONE: begin
          if (!leaving_r) begin
            leaving_nxt  = 1'b1;
            alive_nxt    = alive_r & ~self_bit;
            // non-peers count as having said goodbye already
            gb_nxt       = ~live;
            go_nxt       = live_cnt;
            if (live_cnt == '0) done_nxt = 1'b1;
            ev_set_a     = deferred_r & member_mask;
            ev_a_kind    = M_REPLY;
            deferred_nxt = '0;
            ev_set_b     = live;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pick the next message: grant, first sweep, second sweep, then the tail
  assign idx_a = lowest_idx(set_a_r);
  assign idx_b = lowest_idx(set_b_r);
  assign rem_a = set_a_r & ~(MAX_NODES'(1) << idx_a);
  assign rem_b = set_b_r & ~(MAX_NODES'(1) << idx_b);

  always_comb begin
    pick_kind = tail_kind_r;
    pick_dest = tail_dest_r;
    pick_seq  = '0;
    pick_last = 1'b1;
    grant_nxt = grant_r;
    set_a_nxt = set_a_r;
    set_b_nxt = set_b_r;
    tail_nxt  = tail_r;
    if (grant_r) begin
      pick_kind = M_GRANT;
      pick_dest = '0;
      pick_last = (set_a_r == '0) && (set_b_r == '0) && !tail_r;
      grant_nxt = 1'b0;
    end else if (set_a_r != '0) begin
      pick_kind = a_kind_r;
      pick_dest = ID_W'(idx_a);
      pick_seq  = (a_kind_r == M_REQUEST) ? own_seq_r : '0;
      pick_last = (rem_a == '0) && (set_b_r == '0) && !tail_r;
      set_a_nxt = rem_a;
    end else if (set_b_r != '0) begin
      pick_kind = M_LEAVE;
      pick_dest = ID_W'(idx_b);
      pick_last = (rem_b == '0) && !tail_r;
      set_b_nxt = rem_b;
    end else begin
      tail_nxt  = 1'b0;
    end
  end

  assign stat.last = pick_last;
  assign a_kind_nxt    = ev_a_kind;
  assign tail_kind_nxt = ev_tail_kind;
  assign tail_dest_nxt = ev_tail_dest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      node_count_r <= COUNT_W'(MAX_NODES);
      own_seq_r    <= '0;
      high_seq_r   <= '0;
      requesting_r <= 1'b0;
      ro_r         <= '0;
      replied_r    <= '0;
      deferred_r   <= '0;
      alive_r      <= '1;
      alive_cnt_r  <= CNT_W'(MAX_NODES);
      gb_r         <= '0;
      go_r         <= '0;
      leaving_r    <= 1'b0;
      done_r       <= 1'b0;
      grant_r      <= 1'b0;
      set_a_r      <= '0;
      set_b_r      <= '0;
      tail_r       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        own_seq_r    <= own_seq_nxt;
        high_seq_r   <= high_seq_nxt;
        requesting_r <= requesting_nxt;
        ro_r         <= ro_nxt;
        replied_r    <= replied_nxt;
        deferred_r   <= deferred_nxt;
        alive_r      <= alive_nxt;
        alive_cnt_r  <= alive_cnt_nxt;
        gb_r         <= gb_nxt;
        go_r         <= go_nxt;
        leaving_r    <= leaving_nxt;
        done_r       <= done_nxt;
        grant_r      <= ev_grant;
        set_a_r      <= ev_set_a;
        set_b_r      <= ev_set_b;
        // a no-message item still yields one result
        tail_r       <= ev_tail || !(ev_grant || (ev_set_a != '0) || (ev_set_b != '0));
      end else if (cmd.emit) begin
        grant_r      <= grant_nxt;
        set_a_r      <= set_a_nxt;
        set_b_r      <= set_b_nxt;
        tail_r       <= tail_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ID: node_id_r <= cfg_wdata[ID_W-1:0];
          CFG_NODE_COUNT: begin
            node_count_r <= cfg_wdata[COUNT_W-1:0];
            alive_cnt_r  <= CNT_W'(clamp_count(cfg_wdata[COUNT_W-1:0]));
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_kind_r    <= a_kind_nxt;
      tail_kind_r <= tail_kind_nxt;
      tail_dest_r <= tail_dest_nxt;
    end
    if (cmd.emit) begin
      out_kind_r <= pick_kind;
      out_dest_r <= pick_dest;
      out_seq_r  <= pick_seq;
      out_last_r <= pick_last;
      out_fin_r  <= done_r;
    end
  end

  assign out_message_kind     = out_kind_r;
  assign out_destination_node = out_dest_r;
  assign out_message_sequence = out_seq_r;
  assign out_last_of_run      = out_last_r;
  assign out_finished         = out_fin_r;

endmodule

/* hw/rtl/distributed_mutex_node.sv */
// top level of one distributed mutual exclusion node with graceful departure
//
//   port       dir   flow                 contents
//   in_ch      sink  valid/ready          kind, source_node, sequence_req
//   out_ch     src   valid/ready          message_kind, destination_node,
//                                         message_sequence, last_of_run, finished
//   cfg_*      in    write enable only    node_id (index 0), node_count (index 1)
//
// an item is taken, then its results leave one per cycle while out_ch is ready;
// the single output register and the one-message-per-cycle pick set this rate.
// reset is synchronous and needs no clearing pass.
// a stalled out_ch holds the output register; the next item is taken as soon as
// the last result of the previous one sits in that register.
`include "distributed_mutex_node_defines.svh"

module distributed_mutex_node import dmn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dmn_in_if.sink               in_ch,
  dmn_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmn_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_kind              (in_ch.kind),
    .in_source_node       (in_ch.source_node),
    .in_sequence_req      (in_ch.sequence_req),
    .out_message_kind     (out_ch.message_kind),
    .out_destination_node (out_ch.destination_node),
    .out_message_sequence (out_ch.message_sequence),
    .out_last_of_run      (out_ch.last_of_run),
    .out_finished         (out_ch.finished)
  );

  // busy right after taking an item
  `DMN_ASSERT_NEXT(a_busy_after_accept, cmd.accept, !in_ch.ready)
  // back to taking items once the last result is loaded
  `DMN_ASSERT_NEXT(a_idle_after_last, cmd.emit && stat.last, in_ch.ready)
  // an empty result is always the only one of its item
  `DMN_ASSERT_SAME(a_none_is_last, out_ch.valid && out_ch.message_kind == M_NONE,
                   out_ch.last_of_run)

endmodule

/* test/tb.sv */
// self-checking testbench of the distributed mutex node: directed table, then random rounds
module tb import dmn_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] BAD_KIND = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    msg_kind_t        kind;
    logic [ID_W-1:0]  dest;
    logic [SEQ_W-1:0] seq;
    logic             last;
    logic             fin;
  } mutex_msg_t;

  typedef struct packed {
    logic                 is_cfg;
    logic                 typed;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      src;
    logic [SEQ_W-1:0]     seq;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    mutex_msg_t           want;
  } step_row_t;

  bit clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  dmn_in_if in_ch();
  dmn_out_if out_ch();

  distributed_mutex_node u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // node state as the block should hold it
  logic [ID_W-1:0]      node_id_cfg;
  logic [COUNT_W-1:0]   node_count_cfg;
  logic [SEQ_W-1:0]     own_seq;
  logic [SEQ_W-1:0]     top_seq;
  logic                 in_request;
  logic [4:0]           replies_left;
  logic [MAX_NODES-1:0] replied;
  logic [MAX_NODES-1:0] deferred;
  logic [MAX_NODES-1:0] alive;
  logic [4:0]           alive_count;
  logic [MAX_NODES-1:0] goodbye;
  logic [4:0]           goodbyes_left;
  logic                 leaving;
  logic                 finished_st;

  mutex_msg_t reaction_msgs[$];
  mutex_msg_t pending_msgs[$];
  step_row_t  directed_steps[$];
  mutex_msg_t want;

  int items_sent;
  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic logic [COUNT_W-1:0] eff_count();
    if (node_count_cfg == '0) return COUNT_W'(1);
    if (node_count_cfg > COUNT_W'(MAX_NODES)) return COUNT_W'(MAX_NODES);
    return node_count_cfg;
  endfunction

  function automatic logic [MAX_NODES-1:0] members();
    logic [MAX_NODES:0] m;
    m = '0;
    m[eff_count()] = 1'b1;
    m = m - 1'b1;
    return m[MAX_NODES-1:0];
  endfunction

  function automatic logic [MAX_NODES-1:0] self_mask();
    logic [MAX_NODES-1:0] s;
    s = '0;
    if (node_id_cfg < eff_count()) s[node_id_cfg] = 1'b1;
    return s;
  endfunction

  function automatic logic [MAX_NODES-1:0] live_peers();
    return alive & members() & ~self_mask();
  endfunction

  function automatic void model_reset();
    node_id_cfg = '0;
    node_count_cfg = COUNT_W'(MAX_NODES);
    own_seq = '0;
    top_seq = '0;
    in_request = 1'b0;
    replies_left = '0;
    replied = '0;
    deferred = '0;
    alive = '1;
    alive_count = eff_count();
    goodbye = '0;
    goodbyes_left = '0;
    leaving = 1'b0;
    finished_st = 1'b0;
  endfunction

  function automatic void add_msg(msg_kind_t k, logic [ID_W-1:0] dest, logic [SEQ_W-1:0] s);
    reaction_msgs.push_back('{k, dest, s, 1'b0, 1'b0});
  endfunction

  function automatic void add_to_set(logic [MAX_NODES-1:0] set, msg_kind_t k,
                                     logic [SEQ_W-1:0] s);
    for (int i = 0; i < MAX_NODES; i++) begin
      if (set[i]) add_msg(k, ID_W'(i), s);
    end
  endfunction

  function automatic void take_reply(logic [MAX_NODES-1:0] sbit);
    replied |= sbit;
    if (replies_left > 0) replies_left--;
    if (replies_left == 0) add_msg(M_GRANT, '0, '0);
  endfunction

  function automatic void take_goodbye(logic [MAX_NODES-1:0] sbit);
    goodbye |= sbit;
    if (goodbyes_left > 0) goodbyes_left--;
    if (goodbyes_left == 0) finished_st = 1'b1;
  endfunction

  // messages the node sends in answer to one event
  function automatic void node_react(logic [KIND_W-1:0] kind, logic [ID_W-1:0] src,
                                     logic [SEQ_W-1:0] seq);
    logic [MAX_NODES-1:0] peers;
    logic [MAX_NODES-1:0] sbit;
    logic src_ok;
    sbit = '0;
    sbit[src] = 1'b1;
    src_ok = (src < eff_count()) && (src != node_id_cfg);
    reaction_msgs.delete();
    if (!finished_st) begin
      case (kind)
        IK_LOCAL_REQ: begin
          if (!in_request) begin
            peers = live_peers();
            in_request = 1'b1;
            own_seq = top_seq + 1'b1;
            replied = ~peers;
            replies_left = 5'($countones(peers));
            if (replies_left == 0) add_msg(M_GRANT, '0, '0);
            add_to_set(peers, M_REQUEST, own_seq);
          end
        end
        IK_PEER_REQ: begin
          if (src_ok) begin
            if (seq > top_seq) top_seq = seq;
            // lower sequence wins, ties go to the lower node index
            if (in_request && (seq > own_seq || (seq == own_seq && src > node_id_cfg)))
              deferred |= sbit;
            else
              add_msg(M_REPLY, src, '0);
          end
        end
        IK_PEER_REPLY: begin
          if (src_ok && in_request && !(replied & sbit)) take_reply(sbit);
        end
        IK_RELEASE: begin
          if (in_request) begin
            in_request = 1'b0;
            add_to_set(deferred & members(), M_REPLY, '0);
            deferred = '0;
          end
        end
        IK_LEAVE: begin
          if (src_ok) begin
            if (alive & sbit) begin
              alive &= ~sbit;
              if (alive_count > 0) alive_count--;
            end
            if (in_request && !(replied & sbit)) take_reply(sbit);
            if (leaving && !(goodbye & sbit)) take_goodbye(sbit);
            add_msg(M_GOODBYE, src, '0);
          end
        end
        IK_GOODBYE: begin
          if (src_ok && leaving && !(goodbye & sbit)) take_goodbye(sbit);
        end
        IK_DONE: begin
          if (!leaving) begin
            leaving = 1'b1;
            alive &= ~self_mask();
            peers = live_peers();
            goodbye = ~peers;
            goodbyes_left = 5'($countones(peers));
            if (goodbyes_left == 0) finished_st = 1'b1;
            add_to_set(deferred & members(), M_REPLY, '0);
            deferred = '0;
            add_to_set(peers, M_LEAVE, '0);
          end
        end
        default: begin
        end
      endcase
    end
    if (reaction_msgs.size() == 0) add_msg(M_NONE, '0, '0);
    foreach (reaction_msgs[i]) reaction_msgs[i].fin = finished_st;
    reaction_msgs[reaction_msgs.size()-1].last = 1'b1;
  endfunction

  function automatic step_row_t row_ev(logic [KIND_W-1:0] k, logic [ID_W-1:0] s,
                                       logic [SEQ_W-1:0] q);
    step_row_t r;
    r = '0;
    r.kind = k;
    r.src = s;
    r.seq = q;
    return r;
  endfunction

  function automatic step_row_t row_chk(logic [KIND_W-1:0] k, logic [ID_W-1:0] s,
                                        logic [SEQ_W-1:0] q, msg_kind_t mk,
                                        logic [ID_W-1:0] dest);
    step_row_t r;
    r = row_ev(k, s, q);
    r.typed = 1'b1;
    r.want = '{mk, dest, '0, 1'b1, 1'b0};
    return r;
  endfunction

  function automatic step_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_node(logic [MAX_NODES-1:0] set);
    int i;
    if (set == '0) return ID_W'($urandom_range(0, MAX_NODES - 1));
    do i = $urandom_range(0, MAX_NODES - 1); while (!set[i]);
    return ID_W'(i);
  endfunction

  function automatic logic [SEQ_W-1:0] any_sequence();
    case ($urandom_range(0, 5))
      0: return own_seq;
      1: return own_seq + 1'b1;
      2: return own_seq - 1'b1;
      3: return $urandom;
      4: return top_seq + $urandom_range(0, 3);
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] src,
                           logic [SEQ_W-1:0] seq, logic typed, mutex_msg_t typed_msg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    node_react(kind, src, seq);
    if (typed) pending_msgs.push_back(typed_msg);
    else foreach (reaction_msgs[i]) pending_msgs.push_back(reaction_msgs[i]);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.source_node <= src;
    in_ch.sequence_req <= seq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] src,
                            logic [SEQ_W-1:0] seq);
    send_item(kind, src, seq, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_NODE_ID) begin
      node_id_cfg = val[ID_W-1:0];
    end else begin
      node_count_cfg = val;
      alive_count = eff_count();
    end
  endtask

  task automatic pick_config();
    int dice;
    logic [CFG_W-1:0] cnt;
    dice = $urandom_range(0, 9);
    if (dice < 6) cnt = CFG_W'($urandom_range(2, 6));
    else if (dice == 6) cnt = CFG_W'(MAX_NODES);
    else if (dice == 7) cnt = CFG_W'($urandom_range(17, 31));
    else if (dice == 8) cnt = CFG_W'($urandom_range(0, 1));
    else cnt = CFG_W'($urandom_range(7, 15));
    write_reg(CFG_NODE_COUNT, cnt);
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_NODE_ID, CFG_W'($urandom_range(0, eff_count() - 1)));
    else write_reg(CFG_NODE_ID, CFG_W'($urandom_range(0, 31)));
  endtask

  task automatic noise_item();
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(0, 7));
    // keep the node alive and its peers mostly alive
    if (k == IK_DONE || (k == IK_LEAVE && $urandom_range(0, 2) != 0)) k = IK_GOODBYE;
    send_event(k, ID_W'($urandom), any_sequence());
  endtask

  // one critical section: request, answers from the peers with traffic mixed in, mostly a release
  task automatic request_round();
    logic [MAX_NODES-1:0] awaiting;
    int dice;
    send_event(IK_LOCAL_REQ, ID_W'($urandom), $urandom);
    awaiting = in_request ? (~replied & members()) : '0;
    while (awaiting != '0) begin
      dice = $urandom_range(0, 99);
      if (dice < 55) send_event(IK_PEER_REPLY, pick_node(awaiting), $urandom);
      else if (dice < 80) send_event(IK_PEER_REQ, pick_node(live_peers()), any_sequence());
      else if (dice < 83) send_event(IK_LEAVE, pick_node(awaiting), $urandom);
      else noise_item();
      awaiting = in_request ? (~replied & members()) : '0;
    end
    if ($urandom_range(0, 9) != 0) send_event(IK_RELEASE, ID_W'($urandom), $urandom);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_msgs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d dest %0d seq %h last %b fin %b", $time,
                 out_ch.message_kind, out_ch.destination_node, out_ch.message_sequence,
                 out_ch.last_of_run, out_ch.finished);
      end else begin
        want = pending_msgs.pop_front();
        if (out_ch.message_kind !== want.kind || out_ch.destination_node !== want.dest ||
            out_ch.message_sequence !== want.seq || out_ch.last_of_run !== want.last ||
            out_ch.finished !== want.fin) begin
          mismatches++;
          $display("%0t: expected kind %0d dest %0d seq %h last %b fin %b", $time,
                   want.kind, want.dest, want.seq, want.last, want.fin);
          $display("%0t: actual   kind %0d dest %0d seq %h last %b fin %b", $time,
                   out_ch.message_kind, out_ch.destination_node, out_ch.message_sequence,
                   out_ch.last_of_run, out_ch.finished);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("distributed_mutex_node: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold while the sender keeps offering
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int phase_end[3];
    int dice;
    logic [ID_W-1:0] node;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= '0;
    in_ch.source_node <= '0;
    in_ch.sequence_req <= '0;
    items_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 18;
    recv_idle_pct = 70;
    phase_end = '{95, 165, 225};
    model_reset();

    // defaults: node 0 of 16
    directed_steps.push_back(row_chk(BAD_KIND, 4'd0, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_chk(IK_RELEASE, 4'd0, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_chk(IK_PEER_REPLY, 4'd3, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_chk(IK_PEER_REQ, 4'd0, 32'd5, M_NONE, 4'd0));
    directed_steps.push_back(row_chk(IK_PEER_REQ, 4'd15, 32'hFFFF_FFFF, M_REPLY, 4'd15));
    // own sequence wraps to zero
    directed_steps.push_back(row_ev(IK_LOCAL_REQ, 4'd9, 32'hFFFF_FFFF));
    directed_steps.push_back(row_chk(IK_LOCAL_REQ, 4'd0, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_ev(IK_PEER_REQ, 4'd5, 32'd0));
    directed_steps.push_back(row_ev(IK_PEER_REQ, 4'd7, 32'hFFFF_FFFF));
    directed_steps.push_back(row_ev(IK_PEER_REPLY, 4'd1, 32'd0));
    directed_steps.push_back(row_chk(IK_PEER_REPLY, 4'd1, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_ev(IK_LEAVE, 4'd2, 32'd0));
    directed_steps.push_back(row_chk(IK_LEAVE, 4'd2, 32'd0, M_GOODBYE, 4'd2));
    directed_steps.push_back(row_chk(IK_GOODBYE, 4'd3, 32'd0, M_NONE, 4'd0));
    directed_steps.push_back(row_ev(IK_RELEASE, 4'd0, 32'd0));
    // count of zero clamps to a lone node: immediate grant
    directed_steps.push_back(row_cfg(CFG_NODE_COUNT, 5'd0));
    directed_steps.push_back(row_cfg(CFG_NODE_ID, 5'd0));
    directed_steps.push_back(row_ev(IK_LOCAL_REQ, 4'd0, 32'd0));
    directed_steps.push_back(row_chk(IK_PEER_REQ, 4'd0, 32'd1, M_NONE, 4'd0));
    directed_steps.push_back(row_chk(IK_PEER_REQ, 4'd1, 32'd1, M_NONE, 4'd0));
    directed_steps.push_back(row_ev(IK_RELEASE, 4'd0, 32'd0));
    // node index outside the group
    directed_steps.push_back(row_cfg(CFG_NODE_COUNT, 5'd4));
    directed_steps.push_back(row_cfg(CFG_NODE_ID, 5'd15));
    directed_steps.push_back(row_ev(IK_LOCAL_REQ, 4'd0, 32'd0));
    directed_steps.push_back(row_ev(IK_PEER_REQ, 4'd3, 32'd0));
    directed_steps.push_back(row_ev(IK_PEER_REPLY, 4'd0, 32'd0));
    directed_steps.push_back(row_ev(IK_LEAVE, 4'd1, 32'd0));
    directed_steps.push_back(row_ev(IK_PEER_REPLY, 4'd3, 32'd0));
    directed_steps.push_back(row_ev(IK_RELEASE, 4'd0, 32'd0));
    directed_steps.push_back(row_cfg(CFG_NODE_COUNT, 5'd31));
    directed_steps.push_back(row_chk(IK_PEER_REQ, 4'd15, 32'd0, M_NONE, 4'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_drained();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_item(directed_steps[i].kind, directed_steps[i].src, directed_steps[i].seq,
                  directed_steps[i].typed, directed_steps[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 18 : 0;
      wait_drained();
      pick_config();
      while (items_sent < phase_end[ph]) begin
        dice = $urandom_range(0, 99);
        if (dice < 6) begin
          wait_drained();
          pick_config();
        end else if (dice < 25) begin
          noise_item();
        end else begin
          request_round();
        end
      end
    end

    // shutdown: deferred reply, repeated done, goodbyes until finished, then ignored items
    wait_drained();
    write_reg(CFG_NODE_COUNT, 5'd8);
    write_reg(CFG_NODE_ID, CFG_W'($urandom_range(0, 7)));
    send_event(IK_LOCAL_REQ, 4'd0, 32'd0);
    if (live_peers() != '0) send_event(IK_PEER_REQ, pick_node(live_peers()), own_seq + 1'b1);
    send_event(IK_DONE, ID_W'($urandom), $urandom);
    send_event(IK_DONE, ID_W'($urandom), $urandom);
    while (!finished_st) begin
      node = pick_node(~goodbye & members());
      send_event(($urandom_range(0, 2) == 0) ? IK_LEAVE : IK_GOODBYE, node, $urandom);
    end
    send_event(IK_LOCAL_REQ, ID_W'($urandom), $urandom);
    send_event(IK_PEER_REQ, pick_node(~self_mask() & members()), $urandom);
    send_event(IK_DONE, ID_W'($urandom), $urandom);

    wait_drained();
    repeat (32) @(posedge clk);
    if (mismatches == 0 && pending_msgs.size() == 0) begin
      $display("distributed_mutex_node: match");
    end else begin
      $display("distributed_mutex_node: mismatch");
    end
    $finish;
  end

endmodule
